// File: rtl/core/rv64alu_pkg.sv
package rv64alu_pkg;

  typedef enum logic [5:0] {
    OP_ADD    = 6'd0,
    OP_ADDI   = 6'd1,
    OP_ADDIW  = 6'd2,
    OP_ADDW   = 6'd3,
    OP_AND    = 6'd4,
    OP_ANDI   = 6'd5,
    OP_DIV    = 6'd6,
    OP_DIVU   = 6'd7,
    OP_DIVUW  = 6'd8,
    OP_DIVW   = 6'd9,
    OP_LUI    = 6'd10,
    OP_MUL    = 6'd11,
    OP_MULW   = 6'd12,
    OP_MULH   = 6'd13,
    OP_MULHSU = 6'd14,
    OP_MULHU  = 6'd15,
    OP_SLTU   = 6'd16,
    OP_SLLIW  = 6'd17,
    OP_SLL    = 6'd18,
    OP_SLLI   = 6'd19,
    OP_SLLW   = 6'd20,
    OP_SLT    = 6'd21,
    OP_SLTI   = 6'd22,
    OP_SLTIU  = 6'd23,
    OP_SRL    = 6'd24,
    OP_SRLI   = 6'd25,
    OP_SRLIW  = 6'd26,
    OP_SRLW   = 6'd27,
    OP_SRA    = 6'd28,
    OP_SRAI   = 6'd29,
    OP_SRAIW  = 6'd30,
    OP_SRAW   = 6'd31,
    OP_SUB    = 6'd32,
    OP_SUBW   = 6'd33,
    OP_REM    = 6'd34,
    OP_REMU   = 6'd35,
    OP_REMW   = 6'd36,
    OP_REMUW  = 6'd37,
    OP_ORI    = 6'd38,
    OP_XORI   = 6'd39,
    OP_XOR    = 6'd40,
    OP_OR     = 6'd41
  } op_t;

  typedef enum logic [1:0] {
    CLS_ALU,
    CLS_MUL,
    CLS_DIV
  } cls_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_MUL,
    BK_DIV
  } bk_state_t;

  typedef struct packed {
    op_t         op;
    cls_t        cls;
    logic        known;
    logic [63:0] a;
    logic [63:0] b;
    logic [4:0]  dest;
  } dec_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
  } bk_stat_t;

  function automatic logic [63:0] sx32(input logic [63:0] x);
    sx32 = {{32{x[31]}}, x[31:0]};
  endfunction

endpackage

// File: rtl/core/rv64alu_front.sv
module rv64alu_front #(
  parameter int QDEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [5:0]         req_type,
  input  logic [63:0]        src1,
  input  logic [63:0]        src2,
  input  logic signed [11:0] imm_i,
  input  logic signed [31:0] imm_u,
  input  logic [4:0]         dest_in,
  output rv64alu_pkg::dec_t  head,
  output logic               head_valid,
  input  logic               head_pop
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(QDEPTH - 1);
  localparam logic [CW-1:0] FULLCNT = CW'(QDEPTH);

  rv64alu_pkg::dec_t dec;
  rv64alu_pkg::dec_t mem [QDEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          wr, rd;
  logic [63:0]   ii, ui;

  // decode: pick operand B, pre-extend W divide operands, classify
  always_comb begin
    ii = {{52{imm_i[11]}}, imm_i};
    ui = {{32{imm_u[31]}}, imm_u};
    dec.op    = rv64alu_pkg::op_t'(req_type);
    dec.known = (req_type <= rv64alu_pkg::OP_OR);
    dec.dest  = dec.known ? dest_in : 5'd0;
    dec.a     = src1;
    dec.b     = src2;
    dec.cls   = rv64alu_pkg::CLS_ALU;
    case (dec.op) inside
      rv64alu_pkg::OP_ADDI, rv64alu_pkg::OP_ADDIW, rv64alu_pkg::OP_ANDI,
      rv64alu_pkg::OP_SLLIW, rv64alu_pkg::OP_SLLI, rv64alu_pkg::OP_SLTI,
      rv64alu_pkg::OP_SLTIU, rv64alu_pkg::OP_SRLI, rv64alu_pkg::OP_SRLIW,
      rv64alu_pkg::OP_SRAI, rv64alu_pkg::OP_SRAIW, rv64alu_pkg::OP_ORI,
      rv64alu_pkg::OP_XORI: begin
        dec.b = ii;
      end
      rv64alu_pkg::OP_LUI: begin
        dec.b = ui;
      end
      rv64alu_pkg::OP_MUL, rv64alu_pkg::OP_MULW, rv64alu_pkg::OP_MULH,
      rv64alu_pkg::OP_MULHSU, rv64alu_pkg::OP_MULHU: begin
        dec.cls = rv64alu_pkg::CLS_MUL;
      end
      rv64alu_pkg::OP_DIVW, rv64alu_pkg::OP_REMW: begin
        dec.cls = rv64alu_pkg::CLS_DIV;
        dec.a   = rv64alu_pkg::sx32(src1);
        dec.b   = rv64alu_pkg::sx32(src2);
      end
      rv64alu_pkg::OP_DIVUW, rv64alu_pkg::OP_REMUW: begin
        dec.cls = rv64alu_pkg::CLS_DIV;
        dec.a   = {32'd0, src1[31:0]};
        dec.b   = {32'd0, src2[31:0]};
      end
      rv64alu_pkg::OP_DIV, rv64alu_pkg::OP_DIVU, rv64alu_pkg::OP_REM,
      rv64alu_pkg::OP_REMU: begin
        dec.cls = rv64alu_pkg::CLS_DIV;
      end
      default: begin
        dec.cls = rv64alu_pkg::CLS_ALU;
      end
    endcase
  end

  assign full       = (count == FULLCNT);
  assign head_valid = (count != '0);
  assign wr         = push && !full;
  assign rd         = head_pop && head_valid;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/rv64alu_mul.sv
module rv64alu_mul (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rv64alu_pkg::op_t  op,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  output logic              busy,
  output logic              done,
  output logic [63:0]       result
);

  // step numbers: four 32x32 partial products, then two high-half fixups
  localparam logic [2:0] S_LL  = 3'd0;
  localparam logic [2:0] S_LH  = 3'd1;
  localparam logic [2:0] S_HL  = 3'd2;
  localparam logic [2:0] S_HH  = 3'd3;
  localparam logic [2:0] S_ACC = 3'd4;
  localparam logic [2:0] S_FXA = 3'd5;
  localparam logic [2:0] S_FXB = 3'd6;

  rv64alu_pkg::op_t op_r;
  logic [63:0]  a_r, b_r, prod;
  logic [127:0] acc;
  logic [2:0]   step;
  logic [31:0]  ma, mb;
  logic [63:0]  corr_a, corr_b;

  always_comb begin
    ma = a_r[31:0];
    mb = b_r[31:0];
    case (step)
      S_LH:    begin ma = a_r[31:0];  mb = b_r[63:32]; end
      S_HL:    begin ma = a_r[63:32]; mb = b_r[31:0];  end
      S_HH:    begin ma = a_r[63:32]; mb = b_r[63:32]; end
      default: begin ma = a_r[31:0];  mb = b_r[31:0];  end
    endcase
    corr_a = (a_r[63] && (op_r == rv64alu_pkg::OP_MULH ||
                          op_r == rv64alu_pkg::OP_MULHSU)) ? b_r : 64'd0;
    corr_b = (b_r[63] && op_r == rv64alu_pkg::OP_MULH) ? a_r : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      op_r <= op;
      acc  <= '0;
    end else if (busy) begin
      if (step <= S_HH) begin
        prod <= ma * mb;
      end
      case (step)
        S_LH:    acc <= acc + {64'd0, prod};
        S_HL:    acc <= acc + {32'd0, prod, 32'd0};
        S_HH:    acc <= acc + {32'd0, prod, 32'd0};
        S_ACC:   acc <= acc + {prod, 64'd0};
        S_FXA:   acc[127:64] <= acc[127:64] - corr_a;
        S_FXB:   acc[127:64] <= acc[127:64] - corr_b;
        default: acc <= acc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= S_LL;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == S_FXB) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    case (op_r)
      rv64alu_pkg::OP_MUL:  result = acc[63:0];
      rv64alu_pkg::OP_MULW: result = rv64alu_pkg::sx32(acc[63:0]);
      default:              result = acc[127:64];
    endcase
  end

endmodule

// File: rtl/core/rv64alu_div.sv
module rv64alu_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rv64alu_pkg::op_t  op,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  output logic              busy,
  output logic              done,
  output logic [63:0]       result
);

  localparam logic [5:0] LAST_BIT = 6'd63;

  logic        sgn, na, nb, na_r, nb_r, zero_r, want_rem, word;
  logic        fin;
  logic [5:0]  cnt;
  logic [63:0] quo, rem, mb;
  logic [64:0] trial;
  logic [63:0] q_s, r_s, pick;
  rv64alu_pkg::op_t op_r;

  assign sgn = (op == rv64alu_pkg::OP_DIV) || (op == rv64alu_pkg::OP_DIVW) ||
               (op == rv64alu_pkg::OP_REM) || (op == rv64alu_pkg::OP_REMW);
  assign na  = sgn && a[63];
  assign nb  = sgn && b[63];

  assign want_rem = (op_r == rv64alu_pkg::OP_REM) || (op_r == rv64alu_pkg::OP_REMU) ||
                    (op_r == rv64alu_pkg::OP_REMW) || (op_r == rv64alu_pkg::OP_REMUW);
  assign word     = (op_r == rv64alu_pkg::OP_DIVW) || (op_r == rv64alu_pkg::OP_DIVUW) ||
                    (op_r == rv64alu_pkg::OP_REMW) || (op_r == rv64alu_pkg::OP_REMUW);

  // restoring step: shift in the next dividend bit, try subtracting
  assign trial = {rem, quo[63]} - {1'b0, mb};

  always_comb begin
    q_s  = zero_r ? '1 : ((na_r ^ nb_r) ? 64'd0 - quo : quo);
    r_s  = na_r ? 64'd0 - rem : rem;
    pick = want_rem ? r_s : q_s;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r   <= op;
      na_r   <= na;
      nb_r   <= nb;
      zero_r <= (b == 64'd0);
      quo    <= na ? 64'd0 - a : a;
      mb     <= nb ? 64'd0 - b : b;
      rem    <= '0;
    end else if (busy && !fin) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
    end else if (busy && fin) begin
      result <= word ? rv64alu_pkg::sx32(pick) : pick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      if (fin) begin
        busy <= 1'b0;
        done <= 1'b1;
        fin  <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_BIT) begin
          fin <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/rv64alu_back.sv
module rv64alu_back (
  input  logic                  clk,
  input  logic                  rst,
  input  rv64alu_pkg::dec_t     head,
  input  logic                  head_valid,
  output logic                  head_pop,
  output logic                  empty,
  input  logic                  pop,
  output logic [4:0]            dest_out,
  output logic [63:0]           result_value,
  output rv64alu_pkg::bk_stat_t stat
);

  rv64alu_pkg::bk_state_t state, state_next;

  logic        out_free, load;
  logic [63:0] load_val, alu_val;
  logic [4:0]  load_dest, dest_hold;
  logic        mul_start, div_start;
  logic        mul_busy, mul_done, div_busy, div_done;
  logic [63:0] mul_res, div_res;
  logic [5:0]  sh;
  logic [4:0]  shw;
  logic [63:0] a, b;
  logic [31:0] sraw;

  rv64alu_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .op(head.op), .a(head.a), .b(head.b),
    .busy(mul_busy), .done(mul_done), .result(mul_res)
  );

  rv64alu_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .op(head.op), .a(head.a), .b(head.b),
    .busy(div_busy), .done(div_done), .result(div_res)
  );

  assign stat.mul_busy = mul_busy;
  assign stat.div_busy = div_busy;

  // combinational ALU operations on the queue head
  always_comb begin
    a    = head.a;
    b    = head.b;
    sh   = b[5:0];
    shw  = b[4:0];
    sraw = $signed(a[31:0]) >>> shw;
    case (head.op)
      rv64alu_pkg::OP_ADD, rv64alu_pkg::OP_ADDI:   alu_val = a + b;
      rv64alu_pkg::OP_ADDW, rv64alu_pkg::OP_ADDIW: alu_val = rv64alu_pkg::sx32(a + b);
      rv64alu_pkg::OP_SUB:                         alu_val = a - b;
      rv64alu_pkg::OP_SUBW:                        alu_val = rv64alu_pkg::sx32(a - b);
      rv64alu_pkg::OP_AND, rv64alu_pkg::OP_ANDI:   alu_val = a & b;
      rv64alu_pkg::OP_OR, rv64alu_pkg::OP_ORI:     alu_val = a | b;
      rv64alu_pkg::OP_XOR, rv64alu_pkg::OP_XORI:   alu_val = a ^ b;
      rv64alu_pkg::OP_LUI:                         alu_val = b;
      rv64alu_pkg::OP_SLT, rv64alu_pkg::OP_SLTI:
        alu_val = {63'd0, ($signed(a) < $signed(b))};
      rv64alu_pkg::OP_SLTU, rv64alu_pkg::OP_SLTIU: alu_val = {63'd0, (a < b)};
      rv64alu_pkg::OP_SLL, rv64alu_pkg::OP_SLLI:   alu_val = a << sh;
      rv64alu_pkg::OP_SLLW, rv64alu_pkg::OP_SLLIW: alu_val = rv64alu_pkg::sx32(a << shw);
      rv64alu_pkg::OP_SRL, rv64alu_pkg::OP_SRLI:   alu_val = a >> sh;
      rv64alu_pkg::OP_SRLW, rv64alu_pkg::OP_SRLIW:
        alu_val = rv64alu_pkg::sx32({32'd0, a[31:0] >> shw});
      rv64alu_pkg::OP_SRA, rv64alu_pkg::OP_SRAI:   alu_val = $signed(a) >>> sh;
      rv64alu_pkg::OP_SRAW, rv64alu_pkg::OP_SRAIW:
        alu_val = rv64alu_pkg::sx32({32'd0, sraw});
      default:                                     alu_val = 64'd0;
    endcase
    if (!head.known) begin
      alu_val = 64'd0;
    end
  end

  assign out_free = empty || pop;

  always_comb begin
    state_next = state;
    case (state)
      rv64alu_pkg::BK_RUN: begin
        if (head_valid && head.cls == rv64alu_pkg::CLS_MUL) begin
          state_next = rv64alu_pkg::BK_MUL;
        end else if (head_valid && head.cls == rv64alu_pkg::CLS_DIV) begin
          state_next = rv64alu_pkg::BK_DIV;
        end
      end
      rv64alu_pkg::BK_MUL: begin
        if (mul_done && out_free) begin
          state_next = rv64alu_pkg::BK_RUN;
        end
      end
      rv64alu_pkg::BK_DIV: begin
        if (div_done && out_free) begin
          state_next = rv64alu_pkg::BK_RUN;
        end
      end
      default: state_next = rv64alu_pkg::BK_RUN;
    endcase
  end

  always_comb begin
    head_pop  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    load      = 1'b0;
    load_val  = alu_val;
    load_dest = head.dest;
    case (state)
      rv64alu_pkg::BK_RUN: begin
        if (head_valid) begin
          case (head.cls)
            rv64alu_pkg::CLS_MUL: begin
              head_pop  = 1'b1;
              mul_start = 1'b1;
            end
            rv64alu_pkg::CLS_DIV: begin
              head_pop  = 1'b1;
              div_start = 1'b1;
            end
            default: begin
              head_pop = out_free;
              load     = out_free;
            end
          endcase
        end
      end
      rv64alu_pkg::BK_MUL: begin
        load      = mul_done && out_free;
        load_val  = mul_res;
        load_dest = dest_hold;
      end
      rv64alu_pkg::BK_DIV: begin
        load      = div_done && out_free;
        load_val  = div_res;
        load_dest = dest_hold;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_start || div_start) begin
      dest_hold <= head.dest;
    end
    if (load) begin
      result_value <= load_val;
      dest_out     <= load_dest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rv64alu_pkg::BK_RUN;
      empty <= 1'b1;
    end else begin
      state <= state_next;
      if (load) begin
        empty <= 1'b0;
      end else if (pop) begin
        empty <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/rv64im_integer_alu.sv
// RV64IM integer ALU. Push issued instructions (req_type, src1, src2, imm_i,
// imm_u, dest_in) while full is low; pop results (dest_out, result_value) in
// issue order while empty is low. A front end decodes each transaction and
// queues it (QDEPTH entries); a back end executes from the queue head into a
// one-entry output register, so input and output stall independently.
// Add/sub, logic, shifts, compares and LUI complete at one per cycle while
// the output register is empty or popped; with an idle back end the result
// passes through the queue and the output register to the ports. Multiplies
// run on a shared 32x32 multiplier: the back end takes the queue head, four
// partial products, an accumulate step and two high-half corrections follow,
// then the result is loaded into the output register. Divides and remainders
// use a radix-2 restoring divider: the back end takes the queue head, 64
// quotient bits and a sign fix follow, then the result is loaded into the
// output register. Long operations block the queue head until their result
// is in the output register. Division by zero and signed overflow follow the
// RISC-V M rules; codes 42..63 return dest_out 0 and result_value 0.
module rv64im_integer_alu #(
  parameter int QDEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [5:0]         req_type,
  input  logic [63:0]        src1,
  input  logic [63:0]        src2,
  input  logic signed [11:0] imm_i,
  input  logic signed [31:0] imm_u,
  input  logic [4:0]         dest_in,
  output logic               empty,
  input  logic               pop,
  output logic [4:0]         dest_out,
  output logic [63:0]        result_value
);

  rv64alu_pkg::dec_t     head;
  logic                  head_valid, head_pop;
  rv64alu_pkg::bk_stat_t stat;

  // decode + instruction queue
  rv64alu_front #(.QDEPTH(QDEPTH)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .req_type(req_type), .src1(src1), .src2(src2), .imm_i(imm_i),
    .imm_u(imm_u), .dest_in(dest_in),
    .head(head), .head_valid(head_valid), .head_pop(head_pop)
  );

  // execute + output register
  rv64alu_back u_back (
    .clk(clk), .rst(rst), .head(head), .head_valid(head_valid),
    .head_pop(head_pop), .empty(empty), .pop(pop),
    .dest_out(dest_out), .result_value(result_value), .stat(stat)
  );

`ifndef SYNTH
  // out of reset nothing is queued and nothing is waiting
  a_reset_clean: assert property (@(posedge clk) $past(rst) |-> (empty && !full))
    else $error("ALU not clean after reset");

  // only one long operation can be in flight
  a_one_long: assert property (@(posedge clk) disable iff (rst)
    !(stat.mul_busy && stat.div_busy))
    else $error("multiply and divide busy together");

  // a long operation is only started from a popped queue head
  a_long_from_head: assert property (@(posedge clk) disable iff (rst)
    ($rose(stat.mul_busy) || $rose(stat.div_busy)) |-> $past(head_pop && head_valid))
    else $error("long operation started without a queue pop");
`endif

endmodule

// File: bench/rv64im_integer_alu_tb.sv
`timescale 1ns / 100ps

module rv64im_integer_alu_tb;

  localparam int WDOG_LIMIT = 20000;  // > one divide plus max stalls, many times over

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic [5:0]         req_type;
  logic [63:0]        src1;
  logic [63:0]        src2;
  logic signed [11:0] imm_i;
  logic signed [31:0] imm_u;
  logic [4:0]         dest_in;
  logic               empty;
  logic               pop;
  logic [4:0]         dest_out;
  logic [63:0]        result_value;

  // one expected writeback per issued instruction, oldest first
  typedef struct {
    logic [4:0]  dest;
    logic [63:0] value;
  } wb_t;

  wb_t    wb_q[$];
  int     n_err;
  int     n_sent;
  int     n_done;
  int     idle_cycles;
  bit     timed_out;

  rv64im_integer_alu u_top (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .req_type(req_type), .src1(src1), .src2(src2), .imm_i(imm_i),
    .imm_u(imm_u), .dest_in(dest_in), .empty(empty), .pop(pop),
    .dest_out(dest_out), .result_value(result_value)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic logic [63:0] sext32(logic [63:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

  // signed divide/remainder with RISC-V zero and overflow rules
  function automatic logic [63:0] div_signed(logic [63:0] a, logic [63:0] b, bit rem);
    logic [63:0] ma, mb, q, r;
    if (b == 64'd0) return rem ? a : '1;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    r = ma % mb;
    if (rem) return a[63] ? -r : r;
    return (a[63] ^ b[63]) ? -q : q;
  endfunction

  function automatic logic [63:0] div_unsigned(logic [63:0] a, logic [63:0] b, bit rem);
    if (b == 64'd0) return rem ? a : '1;
    return rem ? a % b : a / b;
  endfunction

  function automatic wb_t alu_result(logic [5:0] opc, logic [63:0] a, logic [63:0] b,
                                     logic [11:0] ii12, logic [31:0] ui32,
                                     logic [4:0] rd);
    logic [63:0]  ii, r;
    logic [127:0] prod;
    wb_t          w;
    ii = {{52{ii12[11]}}, ii12};
    r = '0;
    w.dest = rd;
    case (opc)
      rv64alu_pkg::OP_ADD:    r = a + b;
      rv64alu_pkg::OP_ADDI:   r = a + ii;
      rv64alu_pkg::OP_ADDIW:  r = sext32(a + ii);
      rv64alu_pkg::OP_ADDW:   r = sext32(a + b);
      rv64alu_pkg::OP_AND:    r = a & b;
      rv64alu_pkg::OP_ANDI:   r = a & ii;
      rv64alu_pkg::OP_DIV:    r = div_signed(a, b, 0);
      rv64alu_pkg::OP_DIVU:   r = div_unsigned(a, b, 0);
      rv64alu_pkg::OP_DIVUW:
        r = sext32(div_unsigned({32'd0, a[31:0]}, {32'd0, b[31:0]}, 0));
      rv64alu_pkg::OP_DIVW:   r = sext32(div_signed(sext32(a), sext32(b), 0));
      rv64alu_pkg::OP_LUI:    r = {{32{ui32[31]}}, ui32};
      rv64alu_pkg::OP_MUL:    r = a * b;
      rv64alu_pkg::OP_MULW:   r = sext32(a * b);
      rv64alu_pkg::OP_MULH: begin
        prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        r = prod[127:64];
      end
      rv64alu_pkg::OP_MULHSU: begin
        prod = {{64{a[63]}}, a} * {64'd0, b};
        r = prod[127:64];
      end
      rv64alu_pkg::OP_MULHU: begin
        prod = {64'd0, a} * {64'd0, b};
        r = prod[127:64];
      end
      rv64alu_pkg::OP_SLTU:   r = {63'd0, a < b};
      rv64alu_pkg::OP_SLLIW:  r = sext32(a << ii[4:0]);
      rv64alu_pkg::OP_SLL:    r = a << b[5:0];
      rv64alu_pkg::OP_SLLI:   r = a << ii[5:0];
      rv64alu_pkg::OP_SLLW:   r = sext32(a << b[4:0]);
      rv64alu_pkg::OP_SLT:    r = {63'd0, $signed(a) < $signed(b)};
      rv64alu_pkg::OP_SLTI:   r = {63'd0, $signed(a) < $signed(ii)};
      rv64alu_pkg::OP_SLTIU:  r = {63'd0, a < ii};
      rv64alu_pkg::OP_SRL:    r = a >> b[5:0];
      rv64alu_pkg::OP_SRLI:   r = a >> ii[5:0];
      rv64alu_pkg::OP_SRLIW:  r = sext32({32'd0, a[31:0]} >> ii[4:0]);
      rv64alu_pkg::OP_SRLW:   r = sext32({32'd0, a[31:0]} >> b[4:0]);
      rv64alu_pkg::OP_SRA:    r = $signed(a) >>> b[5:0];
      rv64alu_pkg::OP_SRAI:   r = $signed(a) >>> ii[5:0];
      rv64alu_pkg::OP_SRAIW:  r = sext32($signed(sext32(a)) >>> ii[4:0]);
      rv64alu_pkg::OP_SRAW:   r = sext32($signed(sext32(a)) >>> b[4:0]);
      rv64alu_pkg::OP_SUB:    r = a - b;
      rv64alu_pkg::OP_SUBW:   r = sext32(a - b);
      rv64alu_pkg::OP_REM:    r = div_signed(a, b, 1);
      rv64alu_pkg::OP_REMU:   r = div_unsigned(a, b, 1);
      rv64alu_pkg::OP_REMW:   r = sext32(div_signed(sext32(a), sext32(b), 1));
      rv64alu_pkg::OP_REMUW:
        r = sext32(div_unsigned({32'd0, a[31:0]}, {32'd0, b[31:0]}, 1));
      rv64alu_pkg::OP_ORI:    r = a | ii;
      rv64alu_pkg::OP_XORI:   r = a ^ ii;
      rv64alu_pkg::OP_XOR:    r = a ^ b;
      rv64alu_pkg::OP_OR:     r = a | b;
      default:                w.dest = '0;  // unknown codes write back zero to x0
    endcase
    w.value = r;
    return w;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // operand with bias toward corner values
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      4: return sext32({32'd0, 32'h8000_0000});
      5: return {32'h0, $urandom_range(0, 40)};
      6: return {{32{1'b1}}, $urandom()};
      default: return rand64();
    endcase
  endfunction

  // issue one instruction; returns at the falling edge after the transaction is accepted
  task automatic issue(logic [5:0] opc, logic [63:0] a, logic [63:0] b,
                       logic [11:0] ii, logic [31:0] ui, logic [4:0] rd);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push     <= 1'b1;
    req_type <= opc;
    src1     <= a;
    src2     <= b;
    imm_i    <= ii;
    imm_u    <= ui;
    dest_in  <= rd;
    @(posedge clk);
    while (full) @(posedge clk);
    wb_q.push_back(alu_result(opc, a, b, ii, ui, rd));
    n_sent++;
    @(negedge clk);
  endtask

  // pop side: random stall per transaction, then compare with the oldest entry
  initial begin
    int   stall;
    wb_t  w;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      n_done++;
      if (wb_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result dest=%0d value=%h", dest_out, result_value);
      end else begin
        w = wb_q.pop_front();
        if (dest_out !== w.dest || result_value !== w.value) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch #%0d: dest exp %0d got %0d, value exp %h got %h",
                     n_done, w.dest, dest_out, w.value, result_value);
        end
      end
      @(negedge clk);
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired, %0d transactions outstanding", wb_q.size());
      $display("[rv64im_integer_alu] ERROR");
      $finish;
    end
  end

  // every opcode on corner operands, plus shift-amount, divide, LUI and unknown-code cases
  task automatic test_directed();
    logic [5:0] opc;
    for (int k = 0; k <= 41; k += 2) begin
      opc = 6'(k);
      issue(opc, 64'h8000_0000_0000_0000, '1, 12'h800, 32'h8000_0000, 5'd31);
      issue(opc + 6'd1, '1, 64'd0, 12'h7FF, 32'h7FFF_FFFF, 5'd0);
    end
    issue(rv64alu_pkg::OP_DIVW, 64'h0000_0000_8000_0000, 64'h0000_0000_FFFF_FFFF,
          '0, '0, 5'd5);
    issue(rv64alu_pkg::OP_REMW, 64'h0000_0000_8000_0000, 64'h0000_0000_FFFF_FFFF,
          '0, '0, 5'd6);
    issue(rv64alu_pkg::OP_REMUW, 64'hDEAD_BEEF_8765_4321, 64'hFFFF_FFFF_0000_0000,
          '0, '0, 5'd7);
    issue(rv64alu_pkg::OP_SLLW, 64'h1, 64'h3F, '0, '0, 5'd8);
    issue(rv64alu_pkg::OP_SRAIW, 64'h8000_0000, 64'h0, 12'h03F, '0, 5'd9);
    issue(rv64alu_pkg::OP_LUI, '0, '0, '0, 32'h1234_5ABC, 5'd10);
    issue(6'd42, rand64(), rand64(), 12'h555, 32'h5555_5555, 5'd11);
    issue(6'd63, rand64(), rand64(), 12'hAAA, 32'hAAAA_AAAA, 5'd12);
  endtask

  task automatic test_random(int count);
    logic [5:0] opc;
    logic [63:0] b;
    for (int k = 0; k < count; k++) begin
      // mostly valid ops; a few unknown codes
      opc = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(42, 63))
                                         : 6'($urandom_range(0, 41));
      b = pick_operand();
      if ($urandom_range(0, 15) == 0) b = 64'd0;
      issue(opc, pick_operand(), b, 12'($urandom()), $urandom(), 5'($urandom()));
    end
  endtask

  initial begin
    rst      = 1'b1;
    push     = 1'b0;
    req_type = '0;
    src1     = '0;
    src2     = '0;
    imm_i    = '0;
    imm_u    = '0;
    dest_in  = '0;
    n_err = 0; n_sent = 0; n_done = 0; idle_cycles = 0; timed_out = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random(800);
    push <= 1'b0;

    while (wb_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);  // catch stray results after a divide

    $display("issued %0d instructions over all 42 ops and unknown codes, %0d writebacks checked",
             n_sent, n_done);
    $display("corner operands, zero divisors and signed overflow included; %0d errors", n_err);
    if (n_err == 0) $display("[rv64im_integer_alu] OK");
    else $display("[rv64im_integer_alu] ERROR");
    $finish;
  end

endmodule
